// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
// FLS_ASSERT_NOW: the consequent holds in the same cycle as the antecedent.
// FLS_ASSERT_NEXT: the consequent holds in the cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define FLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/fls_pkg.sv =====
`timescale 1ns / 1ps

package fls_pkg;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 8;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 9;
    localparam int STATUS_W = 2;

    localparam int DEFAULT_CAPACITY   = 256;
    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_QUERY  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_RESET  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DEAD = 2'd2
    } t_status;

endpackage

// ===== hw/rtl/fls_if.sv =====
`timescale 1ns / 1ps

interface fls_cmd_if;
    import fls_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  slot_index;
    logic [DATA_W-1:0] write_data;
    logic              has_data;

    modport source (output valid, command, slot_index, write_data, has_data, input ready);
    modport sink   (input valid, command, slot_index, write_data, has_data, output ready);
endinterface

interface fls_rsp_if;
    import fls_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    result_index;
    logic [DATA_W-1:0]   read_data;
    logic                slot_alive;
    logic [CNT_W-1:0]    in_use_count;

    modport source (output valid, status, result_index, read_data, slot_alive, in_use_count,
                    input ready);
    modport sink   (input valid, status, result_index, read_data, slot_alive, in_use_count,
                    output ready);
endinterface

// ===== hw/rtl/fls_ram.sv =====
`timescale 1ns / 1ps

module fls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/free_list_slot_pool.sv =====
// Slot pool with a LIFO free list threaded through freed slots.
// Channels: i_cmd carries one command item (allocate, remove, alive query,
// read, reset); o_rsp returns exactly one result item per command, in order.
// i_cfg_we / i_cfg_wdata write capacity_limit; write it only while idle.
// Timing: an item is taken in the idle state, the memories are read on that
// edge, and the next cycle evaluates, writes back and loads the output
// register. The result is valid once the evaluate cycle fires; a new item
// waits until the last leaves its evaluate cycle; the registered link memory
// read sets this: allocate needs the head slot's link before the next one.
// The output register decouples the sides: i_cmd stays ready while a result
// waits; if the receiver stalls and a second result is ready, the block holds
// in its evaluate cycle until o_rsp.ready frees the register.
// Reset (i_rst_n low, synchronous, or the reset command) empties the pool:
// head, high-water mark and live count go to zero. No clearing pass runs:
// alive bits are trusted only below the high-water mark, and every slot
// below it has been written since the last reset.
`timescale 1ns / 1ps

module free_list_slot_pool #(
    parameter int CAPACITY   = fls_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = fls_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    fls_cmd_if.sink                  i_cmd,
    fls_rsp_if.source                o_rsp,
    input  logic                     i_cfg_we,
    input  logic [fls_pkg::CNT_W-1:0] i_cfg_wdata
);

    `include "assert_macros.svh"

    import fls_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LW   = (CW > CNT_W) ? CW : CNT_W;
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int LINK_W = CW + 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // control state
    t_state          r_state,      n_state;
    logic [CW-1:0]   r_free_head,  n_free_head;
    logic [CW-1:0]   r_high_water, n_high_water;
    logic [CW-1:0]   r_live,       n_live;
    logic [CNT_W-1:0] r_limit,     n_limit;
    logic            r_out_valid,  n_out_valid;

    // held command
    t_cmd            r_cmd,   n_cmd;
    logic [IDX_W-1:0] r_idx,  n_idx;
    logic [DATA_WIDTH-1:0] r_wdata, n_wdata;

    // output register payload
    t_status           r_status,  n_status;
    logic [IDX_W-1:0]  r_res_idx, n_res_idx;
    logic [DATA_W-1:0] r_rdata,   n_rdata;
    logic              r_alive,   n_alive;
    logic [CNT_W-1:0]  r_count,   n_count;

    // memory ports
    logic                  link_we, link_re;
    logic [IW-1:0]         link_waddr, link_raddr;
    logic [LINK_W-1:0]     link_wdata, link_rdata;
    logic                  elem_we, elem_re;
    logic [IW-1:0]         elem_waddr, elem_raddr;
    logic [DATA_WIDTH-1:0] elem_wdata, elem_rdata;

    logic accept, fire, full, in_range, live_slot;
    logic [LW-1:0] eff_limit;

    // link word: alive bit on top, next free slot below
    fls_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    fls_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_re    (elem_re),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign accept       = i_cmd.valid && (r_state == S_IDLE);
    assign fire         = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // clamp limit to the built capacity
    assign eff_limit = (LW'(r_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(r_limit);
    assign full      = LW'(r_live) >= eff_limit;
    assign in_range  = CMPW'(r_idx) < CMPW'(r_high_water);
    assign live_slot = in_range && link_rdata[LINK_W-1];

    // issue reads on acceptance; allocate looks at the head's link
    assign link_re    = accept;
    assign elem_re    = accept;
    assign link_raddr = (t_cmd'(i_cmd.command) == CMD_ALLOC) ? r_free_head[IW-1:0]
                                                             : IW'(i_cmd.slot_index);
    assign elem_raddr = IW'(i_cmd.slot_index);

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_high_water = r_high_water;
        n_live       = r_live;
        n_limit      = r_limit;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_wdata      = r_wdata;
        n_status     = r_status;
        n_res_idx    = r_res_idx;
        n_rdata      = r_rdata;
        n_alive      = r_alive;
        n_count      = r_count;
        link_we      = 1'b0;
        link_waddr   = r_free_head[IW-1:0];
        link_wdata   = '0;
        elem_we      = 1'b0;
        elem_waddr   = r_free_head[IW-1:0];
        elem_wdata   = r_wdata;

        if (i_cfg_we) begin
            n_limit = i_cfg_wdata;
        end

        // drain the output register
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = t_cmd'(i_cmd.command);
                    n_idx   = i_cmd.slot_index;
                    n_wdata = i_cmd.has_data ? DATA_WIDTH'(i_cmd.write_data) : '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_res_idx   = r_idx;
                    n_rdata     = '0;
                    n_alive     = 1'b0;
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (full) begin
                                n_status  = ST_FULL;
                                n_res_idx = '0;
                            end else begin
                                if (r_free_head == r_high_water) begin
                                    n_high_water = r_high_water + CW'(1);
                                    n_free_head  = r_free_head + CW'(1);
                                end else begin
                                    n_free_head = link_rdata[CW-1:0];
                                end
                                link_we    = 1'b1;
                                link_wdata = {1'b1, CW'(0)};
                                elem_we    = 1'b1;
                                n_live     = r_live + CW'(1);
                                n_res_idx  = IDX_W'(r_free_head);
                                n_alive    = 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (live_slot) begin
                                link_we     = 1'b1;
                                link_waddr  = IW'(r_idx);
                                link_wdata  = {1'b0, r_free_head};
                                n_free_head = CW'(r_idx);
                                if (r_live != '0) begin
                                    n_live = r_live - CW'(1);
                                end
                            end else begin
                                n_status = ST_DEAD;
                            end
                        end
                        CMD_READ: begin
                            if (live_slot) begin
                                n_rdata = DATA_W'(elem_rdata);
                                n_alive = 1'b1;
                            end else begin
                                n_status = ST_DEAD;
                            end
                        end
                        CMD_RESET: begin
                            n_free_head  = '0;
                            n_high_water = '0;
                            n_live       = '0;
                        end
                        default: begin
                            n_alive = live_slot;
                        end
                    endcase
                    n_count = CNT_W'(n_live);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_high_water <= '0;
            r_live       <= '0;
            r_limit      <= LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_high_water <= n_high_water;
            r_live       <= n_live;
            r_limit      <= n_limit;
            r_out_valid  <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_wdata   <= n_wdata;
        r_status  <= n_status;
        r_res_idx <= n_res_idx;
        r_rdata   <= n_rdata;
        r_alive   <= n_alive;
        r_count   <= n_count;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.result_index = r_res_idx;
    assign o_rsp.read_data    = r_rdata;
    assign o_rsp.slot_alive   = r_alive;
    assign o_rsp.in_use_count = r_count;

    // the head never passes the high-water mark
    `FLS_ASSERT_NOW(a_head_le_hw, i_clk, i_rst_n, 1'b1, r_free_head <= r_high_water)
    // live slots all lie below the high-water mark
    `FLS_ASSERT_NOW(a_live_le_hw, i_clk, i_rst_n, 1'b1, r_live <= r_high_water)
    // an accepted item moves to the evaluate cycle
    `FLS_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready,
                     r_state == S_EXEC)
    // a pending result is never overwritten while stalled
    `FLS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_rsp.ready, !fire)

endmodule
